/* src/dios_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// dios_pkg: shared types and constants of the daily interval outlet switch
// Payload types of the tick and result channels, the mode register group
// and the fixed time constants.
// ----------------------------------------------------------------------------
package dios_pkg;

  // Time constants, in minutes.
  localparam logic [10:0] DAY_MINUTES  = 11'd1440;
  localparam logic [10:0] HOUR_MINUTES = 11'd60;

  // Configuration port widths.
  localparam int unsigned CFG_INDEX_W = 3;
  localparam int unsigned CFG_DATA_W  = 11;

  // Register indexes of the configuration port.
  localparam logic [CFG_INDEX_W-1:0] REG_AUTO_MODE    = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_MANUAL_LEVEL = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_FIRST_TIME   = 3'd2;

  // Input item: one clock tick.
  typedef struct packed {
    logic [4:0] hour_now;
    logic [5:0] minute_now;
  } tick_t;

  // Result item.
  typedef struct packed {
    logic        relay_on;
    logic        level_changed;
    logic [10:0] next_start;
  } result_t;

  // Mode registers.
  typedef struct packed {
    logic auto_mode;
    logic manual_level;
  } mode_t;

endpackage : dios_pkg
`default_nettype wire

/* src/dios_tick_if.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// dios_tick_if: tick channel
// Valid/ready channel carrying the current hour and minute.
// ----------------------------------------------------------------------------
interface dios_tick_if;
  logic           valid;
  logic           ready;
  dios_pkg::tick_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface : dios_tick_if
`default_nettype wire

/* src/dios_result_if.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// dios_result_if: result channel
// Valid/ready channel carrying the outlet level and next start time.
// ----------------------------------------------------------------------------
interface dios_result_if;
  logic             valid;
  logic             ready;
  dios_pkg::result_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface : dios_result_if
`default_nettype wire

/* src/dios_cfg_regs.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// dios_cfg_regs: configuration register file
// Holds the mode registers and the start and end time of each interval.
// Writes to intervals that are not built are dropped.
// ----------------------------------------------------------------------------
module dios_cfg_regs #(
  parameter int unsigned NUM_INTERVALS = 3
) (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire logic                             write_enable,
  input  wire logic [dios_pkg::CFG_INDEX_W-1:0] write_index,
  input  wire logic [dios_pkg::CFG_DATA_W-1:0]  write_data,
  output dios_pkg::mode_t                       mode,
  output logic [10:0]                           start_time [NUM_INTERVALS],
  output logic [10:0]                           end_time   [NUM_INTERVALS]
);

  // Mode registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      mode <= '0;
    end else if (write_enable) begin
      if (write_index == dios_pkg::REG_AUTO_MODE) begin
        mode.auto_mode <= write_data[0];
      end
      if (write_index == dios_pkg::REG_MANUAL_LEVEL) begin
        mode.manual_level <= write_data[0];
      end
    end
  end

  // Interval times: start at an even offset from the first time register,
  // end at the odd one after it.
  for (genvar i = 0; i < NUM_INTERVALS; i++) begin : g_slot
    localparam logic [dios_pkg::CFG_INDEX_W-1:0] StartIdx =
      dios_pkg::CFG_INDEX_W'(int'(dios_pkg::REG_FIRST_TIME) + 2 * i);
    localparam logic [dios_pkg::CFG_INDEX_W-1:0] EndIdx =
      dios_pkg::CFG_INDEX_W'(int'(dios_pkg::REG_FIRST_TIME) + 2 * i + 1);

    always_ff @(posedge clk) begin
      if (rst) begin
        start_time[i] <= '0;
        end_time[i]   <= '0;
      end else if (write_enable) begin
        if (write_index == StartIdx) begin
          start_time[i] <= write_data[10:0];
        end
        if (write_index == EndIdx) begin
          end_time[i] <= write_data[10:0];
        end
      end
    end
  end

endmodule : dios_cfg_regs
`default_nettype wire

/* src/dios_eval.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// dios_eval: schedule evaluation
// Forms minutes since midnight, decides the outlet level and picks the
// next start time from the enabled intervals.
// ----------------------------------------------------------------------------
module dios_eval #(
  parameter int unsigned NUM_INTERVALS = 3
) (
  input  wire dios_pkg::tick_t tick_data,
  input  wire dios_pkg::mode_t mode,
  input  wire logic [10:0] start_time [NUM_INTERVALS],
  input  wire logic [10:0] end_time   [NUM_INTERVALS],
  output logic             level,
  output logic [10:0]      next_start
);

  logic [10:0] t_now;
  logic        sched_on;

  // Minutes since midnight; out-of-range fields are not wrapped.
  assign t_now = 11'(tick_data.hour_now) * dios_pkg::HOUR_MINUTES
               + 11'(tick_data.minute_now);

  // An interval covers the time if it is enabled and the time lies in it,
  // with wrap past midnight when the end is before the start.
  always_comb begin
    sched_on = 1'b0;
    for (int i = 0; i < NUM_INTERVALS; i++) begin
      if (start_time[i] < end_time[i]) begin
        if (t_now >= start_time[i] && t_now < end_time[i]) begin
          sched_on = 1'b1;
        end
      end else if (end_time[i] < start_time[i]) begin
        if (t_now >= start_time[i] || t_now < end_time[i]) begin
          sched_on = 1'b1;
        end
      end
    end
  end

  assign level = mode.auto_mode ? sched_on : mode.manual_level;

  // Next start: nearest later start, else the earliest start in the day, else
  // interval 0. Strict compares keep the lower index on a tie.
  always_comb begin
    logic [10:0] best;
    logic [10:0] ahead;
    best       = dios_pkg::DAY_MINUTES;
    next_start = start_time[0];
    ahead      = '0;
    for (int i = 0; i < NUM_INTERVALS; i++) begin
      ahead = start_time[i] - t_now;
      if (start_time[i] > t_now && start_time[i] != end_time[i] && ahead < best) begin
        best       = ahead;
        next_start = start_time[i];
      end
    end
    if (best == dios_pkg::DAY_MINUTES) begin
      for (int i = 0; i < NUM_INTERVALS; i++) begin
        if (start_time[i] < best && start_time[i] != end_time[i]) begin
          best       = start_time[i];
          next_start = start_time[i];
        end
      end
    end
  end

endmodule : dios_eval
`default_nettype wire

/* src/daily_interval_outlet_switch.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// daily_interval_outlet_switch: time-of-day schedule switch for one outlet
// Input register, schedule evaluation and result register with the outlet
// level state.
// ----------------------------------------------------------------------------
// Each tick carries the hour and minute of the day and yields exactly one
// result: the outlet level (schedule in automatic mode, manual level
// otherwise), a flag for a level change since the previous tick, and the
// next scheduled start time. One tick is taken every clock cycle unless the
// result channel stalls; a tick waits in the input register, and its result
// is offered from the result register. While a result waits, the input
// register can still take one more tick. The user writes configuration only
// while no tick is in flight; the block itself does not enforce this.
// ----------------------------------------------------------------------------
module daily_interval_outlet_switch #(
  parameter int unsigned NUM_INTERVALS = 3
) (
  input  wire logic                             clk,
  input  wire logic                             rst,
  dios_tick_if.sink                             tick,
  dios_result_if.source                         result,
  input  wire logic                             write_enable,
  input  wire logic [dios_pkg::CFG_INDEX_W-1:0] write_index,
  input  wire logic [dios_pkg::CFG_DATA_W-1:0]  write_data
);

  dios_pkg::mode_t mode;
  logic [10:0]     start_time [NUM_INTERVALS];
  logic [10:0]     end_time   [NUM_INTERVALS];

  logic            in_valid;
  dios_pkg::tick_t in_data;
  logic            in_advance;
  logic            eval_level;
  logic [10:0]     eval_next_start;
  logic            outlet_level;

  dios_cfg_regs #(
    .NUM_INTERVALS (NUM_INTERVALS)
  ) u_cfg_regs (
    .clk          (clk),
    .rst          (rst),
    .write_enable (write_enable),
    .write_index  (write_index),
    .write_data   (write_data),
    .mode         (mode),
    .start_time   (start_time),
    .end_time     (end_time)
  );

  dios_eval #(
    .NUM_INTERVALS (NUM_INTERVALS)
  ) u_eval (
    .tick_data  (in_data),
    .mode       (mode),
    .start_time (start_time),
    .end_time   (end_time),
    .level      (eval_level),
    .next_start (eval_next_start)
  );

  // Handshake: the input register moves on whenever the result register is
  // empty or its result is being transferred.
  assign in_advance = in_valid && (!result.valid || result.ready);
  assign tick.ready = !in_valid || in_advance;

  // Input register.
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (tick.ready) begin
      in_valid <= tick.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (tick.valid && tick.ready) begin
      in_data <= tick.data;
    end
  end

  // Result register valid.
  always_ff @(posedge clk) begin
    if (rst) begin
      result.valid <= 1'b0;
    end else if (!result.valid || result.ready) begin
      result.valid <= in_valid;
    end
  end

  // Result payload.
  always_ff @(posedge clk) begin
    if (in_advance) begin
      result.data.relay_on      <= eval_level;
      result.data.level_changed <= eval_level != outlet_level;
      result.data.next_start    <= eval_next_start;
    end
  end

  // Outlet level state, updated as each tick leaves the input register.
  always_ff @(posedge clk) begin
    if (rst) begin
      outlet_level <= 1'b0;
    end else if (in_advance) begin
      outlet_level <= eval_level;
    end
  end

  // A tick that leaves the input register always lands in the result register.
  a_advance_fills_result : assert property (@(posedge clk) disable iff (rst)
    in_advance |=> result.valid)
    else $error("result register empty after an advance");

  // The held result agrees with the outlet level state.
  a_level_matches_state : assert property (@(posedge clk) disable iff (rst)
    result.valid |-> result.data.relay_on == outlet_level)
    else $error("result level differs from outlet state");

  // The change flag reports a change of the outlet level state.
  a_change_flag : assert property (@(posedge clk) disable iff (rst)
    in_advance |=> result.data.level_changed == (outlet_level != $past(outlet_level)))
    else $error("level change flag wrong");

  // In manual mode the outlet follows the manual level.
  a_manual_level : assert property (@(posedge clk) disable iff (rst)
    (in_advance && !mode.auto_mode) |=> result.data.relay_on == $past(mode.manual_level))
    else $error("manual level not followed");

endmodule : daily_interval_outlet_switch
`default_nettype wire

/* verif/daily_interval_outlet_switch_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// daily_interval_outlet_switch_tb: self-checking bench for the schedule switch
// Ticks are fed from a backlog by a clocked driver. Each transfer is run
// through a behavioural model of the switch, and the model's answer is queued.
// A clocked monitor compares every result transfer field by field against the
// oldest queued answer. Configuration changes only while the block is idle.
// Both channels insert random idle cycles, and one phase holds the result
// channel off for a long stretch so that the block back-pressures its input.
// ----------------------------------------------------------------------------
module daily_interval_outlet_switch_tb;

  localparam int unsigned NUM_SLOTS       = 3;
  localparam int unsigned MAX_WAIT        = 5;
  localparam int unsigned LONG_HOLD       = 120;
  localparam int unsigned RANDOM_PHASES   = 10;
  localparam int unsigned TICKS_PER_PHASE = 50;
  localparam int unsigned MAX_PRINTS      = 40;

  logic                             clk          = 1'b0;
  logic                             rst          = 1'b1;
  logic                             write_enable = 1'b0;
  logic [dios_pkg::CFG_INDEX_W-1:0] write_index  = '0;
  logic [dios_pkg::CFG_DATA_W-1:0]  write_data   = '0;

  dios_tick_if   tick_ch ();
  dios_result_if result_ch ();

  daily_interval_outlet_switch #(
    .NUM_INTERVALS(NUM_SLOTS)
  ) u_top (
    .clk          (clk),
    .rst          (rst),
    .tick         (tick_ch),
    .result       (result_ch),
    .write_enable (write_enable),
    .write_index  (write_index),
    .write_data   (write_data)
  );

  // Model copy of the configuration and of the outlet level.
  logic        sched_auto;
  logic        sched_manual;
  logic [10:0] sched_start [NUM_SLOTS];
  logic [10:0] sched_end   [NUM_SLOTS];
  logic        outlet_model;

  dios_pkg::tick_t   tick_backlog[$];
  dios_pkg::result_t predicted_results[$];

  // Traffic shaping controls, set by the sequencing block.
  bit src_back_to_back  = 1'b0;
  bit snk_always_ready  = 1'b0;
  bit hold_request      = 1'b0;
  int hold_left;
  int tick_gap;
  int sink_gap;

  int error_count   = 0;
  int ticks_sent    = 0;
  int results_seen  = 0;
  int stall_cycles  = 0;
  int phases_run    = 0;

  always #6 clk = ~clk;

  // Prints one line per mismatch, up to a cap, and counts every one.
  task automatic report_mismatch(string what);
    error_count++;
    if (error_count <= MAX_PRINTS) begin
      $display("[%0t] MISMATCH: %s", $time, what);
    end
  endtask

  // Works out the result of one tick and queues it; updates the level state.
  function automatic void predict_switch(dios_pkg::tick_t tk);
    int unsigned       t;
    int unsigned       best;
    int unsigned       pick;
    logic              on;
    dios_pkg::result_t r;
    t  = int'(tk.hour_now) * int'(dios_pkg::HOUR_MINUTES) + int'(tk.minute_now);
    on = 1'b0;
    for (int i = 0; i < NUM_SLOTS; i++) begin
      if (sched_start[i] < sched_end[i]) begin
        if (t >= sched_start[i] && t < sched_end[i]) on = 1'b1;
      end else if (sched_end[i] < sched_start[i]) begin
        // The interval wraps past midnight.
        if (t >= sched_start[i] || t < sched_end[i]) on = 1'b1;
      end
    end
    // Nearest later enabled start; ties keep the lower index.
    best = dios_pkg::DAY_MINUTES;
    pick = 0;
    for (int i = 0; i < NUM_SLOTS; i++) begin
      if (sched_start[i] > t && sched_start[i] != sched_end[i]) begin
        if (sched_start[i] - t < best) begin
          best = sched_start[i] - t;
          pick = i;
        end
      end
    end
    // Otherwise the earliest enabled start within the day, else interval 0.
    if (best == dios_pkg::DAY_MINUTES) begin
      for (int i = 0; i < NUM_SLOTS; i++) begin
        if (sched_start[i] < best && sched_start[i] != sched_end[i]) begin
          best = sched_start[i];
          pick = i;
        end
      end
    end
    r.relay_on      = sched_auto ? on : sched_manual;
    r.level_changed = (r.relay_on != outlet_model);
    r.next_start    = sched_start[pick];
    outlet_model    = r.relay_on;
    predicted_results.push_back(r);
  endfunction

  // One register write; the model copy follows at once as the block is idle.
  task automatic write_reg(logic [dios_pkg::CFG_INDEX_W-1:0] idx,
                           logic [dios_pkg::CFG_DATA_W-1:0] val);
    int slot;
    @(posedge clk);
    write_enable <= 1'b1;
    write_index  <= idx;
    write_data   <= val;
    case (idx)
      dios_pkg::REG_AUTO_MODE: begin
        sched_auto = val[0];
      end
      dios_pkg::REG_MANUAL_LEVEL: begin
        sched_manual = val[0];
      end
      default: begin
        slot = (int'(idx) - int'(dios_pkg::REG_FIRST_TIME)) / 2;
        if (idx[0] == dios_pkg::REG_FIRST_TIME[0]) sched_start[slot] = val;
        else sched_end[slot] = val;
      end
    endcase
    @(posedge clk);
    write_enable <= 1'b0;
  endtask

  task automatic set_interval(int k, logic [10:0] s, logic [10:0] e);
    write_reg(dios_pkg::REG_FIRST_TIME + dios_pkg::CFG_INDEX_W'(2 * k), s);
    write_reg(dios_pkg::REG_FIRST_TIME + dios_pkg::CFG_INDEX_W'(2 * k + 1), e);
  endtask

  task automatic set_mode(logic auto_bit, logic manual_bit);
    write_reg(dios_pkg::REG_AUTO_MODE, dios_pkg::CFG_DATA_W'(auto_bit));
    write_reg(dios_pkg::REG_MANUAL_LEVEL, dios_pkg::CFG_DATA_W'(manual_bit));
  endtask

  task automatic queue_tick(int h, int m);
    tick_backlog.push_back(dios_pkg::tick_t'{hour_now: 5'(h), minute_now: 6'(m)});
  endtask

  // Waits until no tick is pending or in flight.
  task automatic wait_idle();
    @(negedge clk);
    while (tick_backlog.size() != 0 || tick_ch.valid || predicted_results.size() != 0) begin
      @(negedge clk);
    end
    repeat (4) @(posedge clk);
  endtask

  function automatic logic [10:0] random_time();
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return 11'(dios_pkg::DAY_MINUTES - 1);
      2:       return 11'($urandom_range(dios_pkg::DAY_MINUTES, 2047));
      default: return 11'($urandom_range(0, dios_pkg::DAY_MINUTES - 1));
    endcase
  endfunction

  // Mostly a running clock and times near interval edges, some raw noise.
  task automatic queue_random_ticks(int count);
    int t;
    int kind;
    int k;
    t = $urandom_range(0, dios_pkg::DAY_MINUTES - 1);
    repeat (count) begin
      kind = $urandom_range(0, 9);
      if (kind < 4) begin
        t = (t + 1) % dios_pkg::DAY_MINUTES;
      end else if (kind < 7) begin
        k = $urandom_range(0, NUM_SLOTS - 1);
        t = int'($urandom_range(0, 1) ? sched_start[k] : sched_end[k]);
        t = t + $urandom_range(0, 2) - 1;
        if (t < 0 || t > 31 * 60 + 59) t = $urandom_range(0, dios_pkg::DAY_MINUTES - 1);
      end else if (kind < 9) begin
        t = $urandom_range(0, dios_pkg::DAY_MINUTES - 1);
      end
      if (kind == 9) queue_tick($urandom_range(0, 31), $urandom_range(0, 63));
      else queue_tick(t / 60, t % 60);
    end
  endtask

  // A phase of random configuration followed by random ticks.
  task automatic random_phase(bit back_to_back, bit with_hold);
    logic [10:0] s;
    logic [10:0] e;
    wait_idle();
    src_back_to_back = back_to_back;
    snk_always_ready = back_to_back;
    for (int k = 0; k < NUM_SLOTS; k++) begin
      s = random_time();
      e = ($urandom_range(0, 6) == 0) ? s : random_time();
      set_interval(k, s, e);
    end
    // Upper data bits are random so that the one-bit registers drop them.
    write_reg(dios_pkg::REG_AUTO_MODE, {10'($urandom), 1'($urandom_range(0, 3) != 0)});
    write_reg(dios_pkg::REG_MANUAL_LEVEL, {10'($urandom), 1'($urandom_range(0, 1))});
    @(negedge clk);
    queue_random_ticks(TICKS_PER_PHASE);
    if (with_hold) hold_request = 1'b1;
    phases_run++;
  endtask

  // Tick driver: offers backlog items with a random gap before each one.
  always @(posedge clk) begin : tick_driver
    if (rst) begin
      tick_ch.valid <= 1'b0;
      tick_gap = 0;
    end else begin
      if (tick_ch.valid && !tick_ch.ready) stall_cycles++;
      if (tick_ch.valid && tick_ch.ready) begin
        predict_switch(tick_ch.data);
        ticks_sent++;
        tick_gap = src_back_to_back ? 0 : $urandom_range(0, MAX_WAIT);
      end
      if (!tick_ch.valid || tick_ch.ready) begin
        if (tick_gap > 0) begin
          tick_gap--;
          tick_ch.valid <= 1'b0;
        end else if (tick_backlog.size() != 0) begin
          tick_ch.data  <= tick_backlog.pop_front();
          tick_ch.valid <= 1'b1;
        end else begin
          tick_ch.valid <= 1'b0;
        end
      end
    end
  end

  // Long hold-off of the result channel, counted down here.
  always @(posedge clk) begin : result_hold
    if (rst) begin
      hold_left <= 0;
    end else if (hold_request) begin
      hold_left    <= LONG_HOLD;
      hold_request = 1'b0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end
  end

  // Result monitor: checks each transfer against the oldest prediction.
  always @(posedge clk) begin : result_monitor
    dios_pkg::result_t want;
    dios_pkg::result_t got;
    if (rst) begin
      result_ch.ready <= 1'b0;
      sink_gap = 0;
    end else begin
      if (result_ch.valid && result_ch.ready) begin
        got = result_ch.data;
        results_seen++;
        if (predicted_results.size() == 0) begin
          report_mismatch($sformatf("result %p with no tick outstanding", got));
        end else begin
          want = predicted_results.pop_front();
          if (got.relay_on !== want.relay_on)
            report_mismatch($sformatf("relay_on %b, expected %b",
                                      got.relay_on, want.relay_on));
          if (got.level_changed !== want.level_changed)
            report_mismatch($sformatf("level_changed %b, expected %b",
                                      got.level_changed, want.level_changed));
          if (got.next_start !== want.next_start)
            report_mismatch($sformatf("next_start %0d, expected %0d",
                                      got.next_start, want.next_start));
        end
        sink_gap = snk_always_ready ? 0 : $urandom_range(0, MAX_WAIT);
      end
      if (hold_left != 0) begin
        result_ch.ready <= 1'b0;
      end else if (sink_gap > 0) begin
        sink_gap--;
        result_ch.ready <= 1'b0;
      end else begin
        result_ch.ready <= 1'b1;
      end
    end
  end

  // Sequencing: reset, directed phases, random phases, then the verdict.
  initial begin
    tick_ch.valid   = 1'b0;
    tick_ch.data    = '0;
    result_ch.ready = 1'b0;
    sched_auto      = 1'b0;
    sched_manual    = 1'b0;
    outlet_model    = 1'b0;
    for (int k = 0; k < NUM_SLOTS; k++) begin
      sched_start[k] = '0;
      sched_end[k]   = '0;
    end
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // Reset settings: manual mode, outlet off, every interval disabled.
    @(negedge clk);
    queue_tick(0, 0);
    queue_tick(23, 59);
    queue_tick(31, 63);

    // Manual level on: the first tick changes the level, the next does not.
    wait_idle();
    set_mode(1'b0, 1'b1);
    @(negedge clk);
    queue_tick(12, 0);
    queue_tick(12, 1);

    // Schedule: a daytime interval, one wrapping past midnight, one disabled.
    wait_idle();
    set_interval(0, 11'd480, 11'd1020);
    set_interval(1, 11'd1380, 11'd120);
    set_interval(2, 11'd600, 11'd600);
    set_mode(1'b1, 1'b0);
    @(negedge clk);
    queue_tick(7, 59);
    queue_tick(8, 0);
    queue_tick(16, 59);
    queue_tick(17, 0);
    queue_tick(22, 59);
    queue_tick(23, 0);
    queue_tick(0, 0);
    queue_tick(1, 59);
    queue_tick(2, 0);
    queue_tick(10, 0);
    queue_tick(23, 59);

    // Equal starts go to the lower index; a start beyond the day is never
    // the fallback choice.
    wait_idle();
    set_interval(0, 11'd300, 11'd400);
    set_interval(1, 11'd300, 11'd500);
    set_interval(2, 11'd1500, 11'd1600);
    @(negedge clk);
    queue_tick(4, 0);
    queue_tick(5, 0);
    queue_tick(25, 0);

    // No interval enabled: next start falls back to interval 0's start.
    // Mode registers written with all upper bits set.
    wait_idle();
    set_interval(0, 11'd700, 11'd700);
    set_interval(1, 11'd5, 11'd5);
    set_interval(2, 11'd0, 11'd0);
    write_reg(dios_pkg::REG_AUTO_MODE, 11'h7FF);
    write_reg(dios_pkg::REG_MANUAL_LEVEL, 11'h7FE);
    @(negedge clk);
    queue_tick(12, 0);
    queue_tick(0, 0);
    phases_run = 5;

    for (int p = 0; p < RANDOM_PHASES; p++) begin
      random_phase(p == 2 || p == 3 || p == 7, p == 3);
    end

    wait_idle();
    repeat (8) @(posedge clk);
    $display("Run covered %0d ticks and %0d results over %0d configuration phases.",
             ticks_sent, results_seen, phases_run);
    $display("Result channel held off for %0d cycles; input stalled for %0d cycles.",
             LONG_HOLD, stall_cycles);
    if (error_count == 0) begin
      $display("daily_interval_outlet_switch test passed");
    end else begin
      $display("daily_interval_outlet_switch test failed");
    end
    $finish;
  end

  // Watchdog for a hung handshake.
  initial begin
    #(3_000_000);
    $display("daily_interval_outlet_switch test failed");
    $finish;
  end

endmodule : daily_interval_outlet_switch_tb
